[hdl/mssd_pkg.sv]
// Shared types, codes and the glyph table for the multiplexed seven-segment driver.
// Used by mssd_div and multiplexed_seven_segment_driver_top; depends on nothing.
`default_nettype none
package mssd_pkg;

  localparam logic [1:0] OP_SET_LOW  = 2'd0;
  localparam logic [1:0] OP_SET_HIGH = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam int FRAME_W   = 16;
  localparam int SEG_W     = 8;
  localparam int SEG_DP    = 7;
  localparam int NUMBER_W  = 32;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int ROW_POS_W = 2;
  localparam int POS_W     = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_READ
  } state_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

  // Standard hex glyphs, segments a..g in bits 0..6.
  function automatic logic [6:0] glyph(input logic [DIGIT_W-1:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'h0: seg = 7'h3F;
      4'h1: seg = 7'h06;
      4'h2: seg = 7'h5B;
      4'h3: seg = 7'h4F;
      4'h4: seg = 7'h66;
      4'h5: seg = 7'h6D;
      4'h6: seg = 7'h7D;
      4'h7: seg = 7'h07;
      4'h8: seg = 7'h7F;
      4'h9: seg = 7'h6F;
      4'hA: seg = 7'h77;
      4'hB: seg = 7'h7C;
      4'hC: seg = 7'h58;
      4'hD: seg = 7'h5E;
      4'hE: seg = 7'h79;
      default: seg = 7'h71;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

[hdl/mssd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none
module mssd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/mssd_div.sv]
// Bit-serial restoring divider: 32-bit dividend by a base of 2..16, one bit per cycle.
// Depends on mssd_pkg for widths and the status struct.
`default_nettype none
module mssd_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [mssd_pkg::NUMBER_W-1:0]   dividend,
  input  wire logic [mssd_pkg::RADIX_W-1:0]    divisor,
  output logic      [mssd_pkg::NUMBER_W-1:0]   quotient,
  output mssd_pkg::div_status_t                status
);
  import mssd_pkg::*;

  localparam int CNT_W = $clog2(NUMBER_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   dsor;
  logic [DIGIT_W:0]     trial;
  logic                 fits;
  logic                 done;

  assign trial = {rem, quotient[NUMBER_W-1]};
  assign fits  = (trial >= dsor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(NUMBER_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsor     <= divisor;
      rem      <= '0;
      cnt      <= '0;
    end else if (busy) begin
      // The remainder stays below the divisor, so the difference fits in a digit.
      rem      <= fits ? DIGIT_W'(trial - dsor) : trial[DIGIT_W-1:0];
      quotient <= {quotient[NUMBER_W-2:0], fits};
      cnt      <= cnt + 1'b1;
    end
  end

  assign status.done      = done;
  assign status.remainder = rem;

endmodule
`default_nettype wire

[hdl/multiplexed_seven_segment_driver_top.sv]
// Multiplexed seven-segment driver: command channel, per-digit pattern RAM, frame output.
// Depends on mssd_pkg, mssd_div and mssd_ram.
//
// Usage: commands arrive on cmd_valid/cmd_ready with op, number, point_place and radix.
// A set command (op 0 lower row, op 1 upper row) converts number into DIGITS_PER_ROW
// digits of the clamped base and writes their glyphs into the pattern RAM. Each digit
// passes through the start state, the bit-serial divider steps, one per dividend bit,
// and the write of the digit once the divider is done. A set command occupies the
// block until its last digit is written and produces no transfer on the result channel.
// A tick command (op 2) reads the digit under the scan pointer from the RAM; the pointer
// moves on round-robin as the tick is taken. The read data is registered, then frame
// and digit_index, which are offered on res_valid/res_ready. Op 3 is taken and dropped.
// One command is worked on at a time. While a frame waits for res_ready, set commands
// are still taken, but a tick is held off until the waiting frame is transferred.
// Reset clears the scan pointer and marks every digit as never written, so each digit
// reads as blank (a frame of all ones) until a set command covers it.
`default_nettype none
module multiplexed_seven_segment_driver_top #(
  parameter int DIGIT_COUNT    = 8,
  parameter int DIGITS_PER_ROW = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire logic [1:0]                    op,
  input  wire logic [mssd_pkg::NUMBER_W-1:0] number,
  input  wire logic [1:0]                    point_place,
  input  wire logic [mssd_pkg::RADIX_W-1:0]  radix,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [mssd_pkg::FRAME_W-1:0]       frame,
  output logic [2:0]                         digit_index
);
  import mssd_pkg::*;

  localparam int AW = $clog2(DIGIT_COUNT);
  localparam logic [SEG_W-1:0] SEL_MASK = SEG_W'((1 << DIGIT_COUNT) - 1);

  state_t state, state_next;

  logic [AW-1:0]          scan_ptr;
  logic [AW-1:0]          rd_idx;
  logic [DIGIT_COUNT-1:0] written;

  logic                   row;
  logic [ROW_POS_W-1:0]   k;
  logic [1:0]             point;
  logic [RADIX_W-1:0]     base;
  logic [NUMBER_W-1:0]    value;

  logic                   accept;
  logic                   div_start;
  logic [NUMBER_W-1:0]    quotient;
  div_status_t            div_st;

  logic [POS_W-1:0]       pos;
  logic                   ram_we;
  logic                   ram_re;
  logic [FRAME_W-1:0]     ram_wdata;
  logic [FRAME_W-1:0]     ram_rdata;
  logic [FRAME_W-1:0]     pattern;
  logic                   last_digit;
  logic                   add_point;

  assign cmd_ready = (state == S_IDLE) && (!res_valid || op != OP_TICK);
  assign accept    = cmd_valid && cmd_ready;

  // RAM position of the digit now leaving the divider, least significant digit first.
  assign pos = POS_W'(row) * POS_W'(DIGITS_PER_ROW) + POS_W'(DIGITS_PER_ROW - 1) - POS_W'(k);
  assign last_digit = (k == ROW_POS_W'(DIGITS_PER_ROW - 1));
  assign add_point  = (int'(point) < DIGITS_PER_ROW) && (point == k);
  assign ram_wdata  = {SEL_MASK, add_point, glyph(div_st.remainder)};
  assign ram_we     = (state == S_WAIT) && div_st.done && (pos < POS_W'(DIGIT_COUNT));
  assign ram_re     = accept && op == OP_TICK;
  assign pattern    = written[rd_idx] ? ram_rdata : '0;

  mssd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (value),
    .divisor  (base),
    .quotient (quotient),
    .status   (div_st)
  );

  mssd_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (DIGIT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_ptr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_SET_LOW || op == OP_SET_HIGH) begin
            state_next = S_START;
          end else if (op == OP_TICK) begin
            state_next = S_READ;
          end
        end
      end
      S_START: begin
        div_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (div_st.done) begin
          state_next = last_digit ? S_IDLE : S_START;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_ptr  <= '0;
      written   <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_re) begin
        scan_ptr <= (scan_ptr == AW'(DIGIT_COUNT - 1)) ? '0 : scan_ptr + 1'b1;
      end
      if (ram_we) begin
        written[pos[AW-1:0]] <= 1'b1;
      end
      if (state == S_READ) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row    <= op[0];
      point  <= point_place;
      value  <= number;
      k      <= '0;
      rd_idx <= scan_ptr;
      if (radix < RADIX_MIN) begin
        base <= RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
        base <= RADIX_MAX;
      end else begin
        base <= radix;
      end
    end else if (state == S_WAIT && div_st.done) begin
      value <= quotient;
      k     <= k + 1'b1;
    end
    if (state == S_READ) begin
      frame       <= (FRAME_W'(1) << (SEG_W + int'(rd_idx))) | ~pattern;
      digit_index <= 3'(rd_idx);
    end
  end

endmodule
`default_nettype wire
